/* design/otsb_pkg.sv */
`default_nettype none

package otsb_pkg;

  // field widths of the words
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned INST_FW   = 2;
  localparam int unsigned SLOT_FW   = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RIDX_W    = 6;
  localparam int unsigned KIND_W    = 2;

  // widest slot counter the parameter range needs (up to 16 slots)
  localparam int unsigned SLOT_MAXW = 4;

  // default table shape
  localparam int unsigned NUM_INSTRUMENTS_DEF      = 4;
  localparam int unsigned SLOTS_PER_INSTRUMENT_DEF = 8;

  // update modes
  localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MODIFY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OTHER   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PUBLISH = 3'd4;

  // snapshot record kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ORDER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

  // incoming update or publish word
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INST_FW-1:0] instrument;
    logic [SLOT_FW-1:0] order_slot;
    logic               side;
    logic [DATA_W-1:0]  price;
    logic [DATA_W-1:0]  quantity;
    logic [DATA_W-1:0]  sequence_req;
  } in_t;

  // outgoing snapshot record word
  typedef struct packed {
    logic [RIDX_W-1:0]  record_index;
    logic [KIND_W-1:0]  record_kind;
    logic [INST_FW-1:0] out_instrument;
    logic [DATA_W-1:0]  order_or_sequence;
    logic               out_side;
    logic [DATA_W-1:0]  out_price;
    logic [DATA_W-1:0]  out_quantity;
    logic               last_record;
  } out_t;

  // table lookup from the snapshot walker
  typedef struct packed {
    logic                 rd_en;
    logic [INST_FW-1:0]   inst;
    logic [SLOT_MAXW-1:0] slot;
  } lookup_req_t;

  // live flag is immediate, entry data follows in the cycle after rd_en
  typedef struct packed {
    logic              live;
    logic              side;
    logic [DATA_W-1:0] price;
    logic [DATA_W-1:0] quantity;
  } lookup_rsp_t;

endpackage

`default_nettype wire

/* design/otsb_ram.sv */
`default_nettype none

module otsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/otsb_table.sv */
`default_nettype none

module otsb_table #(
  parameter int unsigned NUM_INSTRUMENTS      = otsb_pkg::NUM_INSTRUMENTS_DEF,
  parameter int unsigned SLOTS_PER_INSTRUMENT = otsb_pkg::SLOTS_PER_INSTRUMENT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 upd_valid_i,
  input  wire otsb_pkg::in_t        upd_i,
  input  wire otsb_pkg::lookup_req_t lookup_i,
  output otsb_pkg::lookup_rsp_t     lookup_o
);

  import otsb_pkg::*;

  localparam int unsigned INST_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int unsigned SLOT_W =
    (SLOTS_PER_INSTRUMENT > 1) ? $clog2(SLOTS_PER_INSTRUMENT) : 1;
  localparam int unsigned ADDR_W = INST_W + SLOT_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned PQ_W   = 2 * DATA_W;

  logic                 live_q [DEPTH];
  logic                 in_range;
  logic [SLOT_MAXW-1:0] upd_slot_ext;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 is_add;
  logic                 is_modify;
  logic                 is_cancel;
  logic                 side_we;
  logic                 pq_we;
  logic [0:0]           side_rdata;
  logic [PQ_W-1:0]      pq_rdata;

  // entry address of the update, only used when in range
  assign in_range = (32'(upd_i.instrument) < NUM_INSTRUMENTS) &&
                    (32'(upd_i.order_slot) < SLOTS_PER_INSTRUMENT);
  assign upd_slot_ext = SLOT_MAXW'(upd_i.order_slot);
  assign wr_addr = {upd_i.instrument[INST_W-1:0], upd_slot_ext[SLOT_W-1:0]};
  assign rd_addr = {lookup_i.inst[INST_W-1:0], lookup_i.slot[SLOT_W-1:0]};

  assign is_add    = upd_valid_i && in_range && (upd_i.mode == MODE_ADD);
  assign is_modify = upd_valid_i && in_range && (upd_i.mode == MODE_MODIFY);
  assign is_cancel = upd_valid_i && in_range && (upd_i.mode == MODE_CANCEL);

  // side only on add, price and quantity on add or on modify of a live slot
  assign side_we = is_add;
  assign pq_we   = is_add || (is_modify && live_q[wr_addr]);

  // live flags in flops, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        live_q[i] <= 1'b0;
      end
    end else if (is_add) begin
      live_q[wr_addr] <= 1'b1;
    end else if (is_cancel) begin
      live_q[wr_addr] <= 1'b0;
    end
  end

  otsb_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_side_ram (
    .clk_i   (clk_i),
    .we_i    (side_we),
    .waddr_i (wr_addr),
    .wdata_i (upd_i.side),
    .re_i    (lookup_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (side_rdata)
  );

  otsb_ram #(
    .WIDTH (PQ_W),
    .DEPTH (DEPTH)
  ) u_pq_ram (
    .clk_i   (clk_i),
    .we_i    (pq_we),
    .waddr_i (wr_addr),
    .wdata_i ({upd_i.price, upd_i.quantity}),
    .re_i    (lookup_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (pq_rdata)
  );

  // lookup response
  assign lookup_o.live     = live_q[rd_addr];
  assign lookup_o.side     = side_rdata[0];
  assign lookup_o.price    = pq_rdata[PQ_W-1:DATA_W];
  assign lookup_o.quantity = pq_rdata[DATA_W-1:0];

  a_add_sets_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_add |=> live_q[$past(wr_addr)])
    else $error("add did not mark slot live");

  a_cancel_clears_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_cancel |=> !live_q[$past(wr_addr)])
    else $error("cancel did not empty slot");

endmodule

`default_nettype wire

/* design/otsb_snap.sv */
`default_nettype none

module otsb_snap #(
  parameter int unsigned NUM_INSTRUMENTS      = otsb_pkg::NUM_INSTRUMENTS_DEF,
  parameter int unsigned SLOTS_PER_INSTRUMENT = otsb_pkg::SLOTS_PER_INSTRUMENT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [otsb_pkg::DATA_W-1:0]   last_seq_i,
  output logic                               busy_o,
  output otsb_pkg::lookup_req_t              lookup_o,
  input  wire otsb_pkg::lookup_rsp_t         lookup_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output otsb_pkg::out_t                     out_o
);

  import otsb_pkg::*;

  localparam int unsigned INST_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int unsigned SLOT_W =
    (SLOTS_PER_INSTRUMENT > 1) ? $clog2(SLOTS_PER_INSTRUMENT) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_CLEAR = 6'b000100,
    S_SCAN  = 6'b001000,
    S_ORDER = 6'b010000,
    S_END   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [INST_W-1:0]    inst_q, inst_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [RIDX_W-1:0]    idx_q, idx_d;
  logic                 out_valid_q;
  out_t                 out_q;
  out_t                 rec;
  logic                 load;
  logic                 out_free;
  logic                 last_slot;
  logic                 last_inst;
  state_e               adv_state;
  logic [INST_W-1:0]    adv_inst;
  logic [SLOT_W-1:0]    adv_slot;
  logic [INST_FW-1:0]   inst_ext;
  logic [SLOT_MAXW-1:0] slot_ext;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_slot = (slot_q == SLOT_W'(SLOTS_PER_INSTRUMENT - 1));
  assign last_inst = (inst_q == INST_W'(NUM_INSTRUMENTS - 1));

  // widen walk position to field widths
  always_comb begin
    inst_ext = '0;
    slot_ext = '0;
    inst_ext[INST_W-1:0] = inst_q;
    slot_ext[SLOT_W-1:0] = slot_q;
  end

  // next position after the current slot
  always_comb begin
    adv_state = S_SCAN;
    adv_inst  = inst_q;
    adv_slot  = slot_q + SLOT_W'(1);
    if (last_slot) begin
      adv_slot = slot_q;
      if (last_inst) begin
        adv_state = S_END;
      end else begin
        adv_state = S_CLEAR;
        adv_inst  = inst_q + INST_W'(1);
      end
    end
  end

  // snapshot walk sequencer
  always_comb begin
    state_d        = state_q;
    inst_d         = inst_q;
    slot_d         = slot_q;
    idx_d          = idx_q;
    load           = 1'b0;
    rec            = '0;
    rec.record_index = idx_q;
    lookup_o.rd_en = 1'b0;
    lookup_o.inst  = inst_ext;
    lookup_o.slot  = slot_ext;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        rec.record_kind       = KIND_START;
        rec.order_or_sequence = last_seq_i;
        if (out_free) begin
          load    = 1'b1;
          idx_d   = idx_q + RIDX_W'(1);
          inst_d  = '0;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        rec.record_kind    = KIND_CLEAR;
        rec.out_instrument = inst_ext;
        if (out_free) begin
          load    = 1'b1;
          idx_d   = idx_q + RIDX_W'(1);
          slot_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (lookup_i.live) begin
          lookup_o.rd_en = 1'b1;
          state_d        = S_ORDER;
        end else begin
          inst_d  = adv_inst;
          slot_d  = adv_slot;
          state_d = adv_state;
        end
      end
      S_ORDER: begin
        rec.record_kind       = KIND_ORDER;
        rec.out_instrument    = inst_ext;
        rec.order_or_sequence = DATA_W'(slot_ext);
        rec.out_side          = lookup_i.side;
        rec.out_price         = lookup_i.price;
        rec.out_quantity      = lookup_i.quantity;
        if (out_free) begin
          load    = 1'b1;
          idx_d   = idx_q + RIDX_W'(1);
          inst_d  = adv_inst;
          slot_d  = adv_slot;
          state_d = adv_state;
        end
      end
      S_END: begin
        rec.record_kind       = KIND_END;
        rec.order_or_sequence = last_seq_i;
        rec.last_record       = 1'b1;
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inst_q      <= '0;
      slot_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inst_q  <= inst_d;
      slot_q  <= slot_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= rec;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_order_is_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ORDER |-> lookup_i.live)
    else $error("order record from an empty slot");

  a_end_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && rec.last_record |=> state_q == S_IDLE)
    else $error("walk did not finish after end record");

  a_start_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_START |-> idx_q == '0)
    else $error("snapshot run does not number from zero");

endmodule

`default_nettype wire

/* design/order_table_snapshot_builder_unit.sv */
// updates (add, modify, cancel, other): one word per cycle while not busy, no result word
// publish: the start state registers the start record after acceptance, then a clear
// record per instrument, a scan step per slot plus a table read and order record for each
// live order, then the end record; input stalls until the end record is registered
// reset: live flags and last sequence clear at once, no clearing pass
`default_nettype none

module order_table_snapshot_builder_unit #(
  parameter int unsigned NUM_INSTRUMENTS      = otsb_pkg::NUM_INSTRUMENTS_DEF,
  parameter int unsigned SLOTS_PER_INSTRUMENT = otsb_pkg::SLOTS_PER_INSTRUMENT_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire otsb_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output otsb_pkg::out_t      out_o
);

  import otsb_pkg::*;

  logic              busy;
  logic              accept;
  logic              upd_valid;
  logic              start;
  logic [DATA_W-1:0] last_seq_q;
  lookup_req_t       lookup_req;
  lookup_rsp_t       lookup_rsp;

  // words are taken only while no snapshot is being walked
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign start      = accept && (in_i.mode == MODE_PUBLISH);
  assign upd_valid  = accept && (in_i.mode != MODE_PUBLISH);

  // last sequence seen on any update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
    end else if (upd_valid) begin
      last_seq_q <= in_i.sequence_req;
    end
  end

  otsb_table #(
    .NUM_INSTRUMENTS      (NUM_INSTRUMENTS),
    .SLOTS_PER_INSTRUMENT (SLOTS_PER_INSTRUMENT)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_valid_i (upd_valid),
    .upd_i       (in_i),
    .lookup_i    (lookup_req),
    .lookup_o    (lookup_rsp)
  );

  otsb_snap #(
    .NUM_INSTRUMENTS      (NUM_INSTRUMENTS),
    .SLOTS_PER_INSTRUMENT (SLOTS_PER_INSTRUMENT)
  ) u_snap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_seq_i  (last_seq_q),
    .busy_o      (busy),
    .lookup_o    (lookup_req),
    .lookup_i    (lookup_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
